FILE: sv/hmsct_pkg.sv
`default_nettype none

package hmsct_pkg;

    typedef enum logic [1:0] {
        MODE_ENTER = 2'd0,
        MODE_SET   = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_TICK  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        GEST_NONE   = 2'd0,
        GEST_TAP    = 2'd1,
        GEST_DOUBLE = 2'd2,
        GEST_LONG   = 2'd3
    } gesture_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_REDRAW  = 3'd1,
        ACT_BACK    = 3'd2,
        ACT_START   = 3'd3,
        ACT_DISMISS = 3'd4,
        ACT_GOSET   = 3'd5
    } action_t;

    localparam logic [1:0] FIELD_HOURS   = 2'd0;
    localparam logic [1:0] FIELD_MINUTES = 2'd1;
    localparam logic [1:0] FIELD_SECONDS = 2'd2;

    localparam logic [4:0] HOURS_LAST = 5'd23;
    localparam logic [5:0] MINSEC_LAST = 6'd59;

    localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN  = 17'd60;
    localparam logic [26:0] MS_PER_HOUR  = 27'd3600000;
    localparam logic [26:0] MS_PER_MIN   = 27'd60000;
    localparam logic [26:0] MS_PER_SEC   = 27'd1000;
    localparam logic [31:0] MS_PER_SEC_W = 32'd1000;

    // floor(y / 125) = (y * DIV_RECIP) >> DIV_SHIFT, exact for y below 2^24
    localparam logic [24:0] DIV_RECIP = 25'd17179870;
    localparam int          DIV_SHIFT = 31;

    localparam logic [16:0] SHOWN_NONE = 17'h1FFFF;

    typedef struct packed {
        action_t     action;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [1:0]  field;
        logic [16:0] remaining;
        logic        running;
        logic        finished;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/hmsct_div1000.sv
`default_nettype none

module hmsct_div1000 (
    input  wire logic [26:0] dividend,
    output logic      [16:0] quotient
);
    import hmsct_pkg::*;

    logic [23:0] eighth;
    logic [48:0] prod;

    // divide by 8 by shifting, then by 125 through a reciprocal multiply
    assign eighth   = dividend[26:3];
    assign prod     = 49'(eighth) * 49'(DIV_RECIP);
    assign quotient = prod[DIV_SHIFT +: 17];

endmodule

`default_nettype wire

FILE: sv/hmsct_core.sv
`default_nettype none

module hmsct_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire hmsct_pkg::mode_t    mode,
    input  wire hmsct_pkg::gesture_t gesture,
    input  wire logic [31:0]        now_ms,
    output hmsct_pkg::result_t       res
);
    import hmsct_pkg::*;

    logic [4:0]  hours_reg, hours_next;
    logic [5:0]  minutes_reg, minutes_next;
    logic [5:0]  seconds_reg, seconds_next;
    logic [1:0]  field_reg, field_next;
    logic [16:0] remaining_reg, remaining_next;
    logic [26:0] rem_ms_reg, rem_ms_next;
    logic [31:0] last_tick_reg, last_tick_next;
    logic [16:0] shown_reg, shown_next;
    logic        started_reg, started_next;
    logic        done_reg, done_next;
    action_t     act;

    logic [16:0] total_sec;
    logic [26:0] total_ms;
    logic [31:0] delta;
    logic        clamp;
    logic [16:0] quot;
    logic [16:0] ticks;
    logic [26:0] quot_ms;
    logic [26:0] ticks_ms;
    logic [16:0] rem_after;

    assign total_sec = 17'(hours_reg) * SEC_PER_HOUR + 17'(minutes_reg) * SEC_PER_MIN
                     + 17'(seconds_reg);
    assign total_ms  = 27'(hours_reg) * MS_PER_HOUR + 27'(minutes_reg) * MS_PER_MIN
                     + 27'(seconds_reg) * MS_PER_SEC;

    // elapsed time; clamped when it covers all that is left
    assign delta = now_ms - last_tick_reg;
    assign clamp = delta >= {5'd0, rem_ms_reg};

    hmsct_div1000 u_div (
        .dividend (delta[26:0]),
        .quotient (quot)
    );

    assign quot_ms   = {quot, 10'd0} - {6'd0, quot, 4'd0} - {7'd0, quot, 3'd0};
    assign ticks     = clamp ? remaining_reg : quot;
    assign ticks_ms  = clamp ? rem_ms_reg : quot_ms;
    assign rem_after = remaining_reg - ticks;

    always_comb begin
        hours_next     = hours_reg;
        minutes_next   = minutes_reg;
        seconds_next   = seconds_reg;
        field_next     = field_reg;
        remaining_next = remaining_reg;
        rem_ms_next    = rem_ms_reg;
        last_tick_next = last_tick_reg;
        shown_next     = shown_reg;
        started_next   = started_reg;
        done_next      = done_reg;
        act            = ACT_NONE;

        unique case (mode)
            MODE_ENTER: begin
                hours_next   = '0;
                minutes_next = '0;
                seconds_next = '0;
                field_next   = FIELD_HOURS;
                started_next = 1'b0;
                done_next    = 1'b0;
            end
            MODE_SET: begin
                unique case (gesture)
                    GEST_TAP: begin
                        act = ACT_REDRAW;
                        unique case (field_reg)
                            FIELD_HOURS:
                                hours_next = (hours_reg == HOURS_LAST) ? 5'd0 : hours_reg + 5'd1;
                            FIELD_MINUTES:
                                minutes_next = (minutes_reg == MINSEC_LAST) ? 6'd0
                                             : minutes_reg + 6'd1;
                            FIELD_SECONDS:
                                seconds_next = (seconds_reg == MINSEC_LAST) ? 6'd0
                                             : seconds_reg + 6'd1;
                            default: ;
                        endcase
                    end
                    GEST_LONG: begin
                        if (field_reg < FIELD_SECONDS) begin
                            field_next = field_reg + 2'd1;
                            act        = ACT_REDRAW;
                        end else if (total_sec == '0) begin
                            act = ACT_BACK;
                        end else begin
                            remaining_next = total_sec;
                            rem_ms_next    = total_ms;
                            shown_next     = SHOWN_NONE;
                            done_next      = 1'b0;
                            started_next   = 1'b0;
                            act            = ACT_START;
                        end
                    end
                    GEST_DOUBLE: act = ACT_BACK;
                    GEST_NONE:   act = ACT_NONE;
                endcase
            end
            MODE_RUN: begin
                priority if (done_reg) begin
                    act = (gesture == GEST_TAP) ? ACT_DISMISS : ACT_NONE;
                end else if (!started_reg) begin
                    if (gesture == GEST_TAP) begin
                        started_next   = 1'b1;
                        last_tick_next = now_ms;
                        act            = ACT_REDRAW;
                    end else if (gesture == GEST_LONG) begin
                        act = ACT_GOSET;
                    end
                end else begin
                    act = (gesture != GEST_NONE) ? ACT_DISMISS : ACT_NONE;
                end
            end
            MODE_TICK: begin
                if (started_reg && !done_reg && delta >= MS_PER_SEC_W) begin
                    remaining_next = rem_after;
                    rem_ms_next    = rem_ms_reg - ticks_ms;
                    last_tick_next = last_tick_reg + 32'(ticks_ms);
                    if (rem_after == '0) begin
                        done_next  = 1'b1;
                        shown_next = '0;
                        act        = ACT_REDRAW;
                    end else if (rem_after != shown_reg) begin
                        shown_next = rem_after;
                        act        = ACT_REDRAW;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hours_reg     <= '0;
            minutes_reg   <= '0;
            seconds_reg   <= '0;
            field_reg     <= FIELD_HOURS;
            remaining_reg <= '0;
            rem_ms_reg    <= '0;
            last_tick_reg <= '0;
            shown_reg     <= SHOWN_NONE;
            started_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end else if (step) begin
            hours_reg     <= hours_next;
            minutes_reg   <= minutes_next;
            seconds_reg   <= seconds_next;
            field_reg     <= field_next;
            remaining_reg <= remaining_next;
            rem_ms_reg    <= rem_ms_next;
            last_tick_reg <= last_tick_next;
            shown_reg     <= shown_next;
            started_reg   <= started_next;
            done_reg      <= done_next;
        end
    end

    always_comb begin
        res.action    = act;
        res.hours     = hours_next;
        res.minutes   = minutes_next;
        res.seconds   = seconds_next;
        res.field     = field_next;
        res.remaining = remaining_next;
        res.running   = started_next;
        res.finished  = done_next;
    end

endmodule

`default_nettype wire

FILE: sv/hms_countdown_timer_with_gestures.sv
`default_nettype none

// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  mode, gesture, now_ms
// m_        out        m_valid / m_ready  action, hours, minutes, seconds, field,
//                                         remaining, running, finished
//
// one beat per clock sustained while m_ready stays high; a result reaches the
// output register through the input register, then the state update
// the timer state is updated in the single cycle that moves an item from the
// input register to the output register, so each item sees the previous one
// reset (aresetn low, synchronous) empties both registers and sets the timer idle
// a stalled m_ready holds the result; the input register still takes one beat

module hms_countdown_timer_with_gestures (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [1:0]  s_gesture,
    input  wire logic [31:0] s_now_ms,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_action,
    output logic [4:0]       m_hours_out,
    output logic [5:0]       m_minutes_out,
    output logic [5:0]       m_seconds_out,
    output logic [1:0]       m_field_out,
    output logic [16:0]      m_remaining_out,
    output logic             m_running_out,
    output logic             m_finished_out
);
    import hmsct_pkg::*;

    // input register
    logic        in_valid_reg;
    mode_t       mode_reg;
    gesture_t    gesture_reg;
    logic [31:0] now_reg;

    // output register
    logic        out_valid_reg;
    result_t     out_reg;

    logic        out_free;
    logic        step;
    result_t     res;

    // output register can take a new result when empty or being drained
    assign out_free = !out_valid_reg || m_ready;
    // an item moves on, and updates the timer, when both stages allow it
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg    <= mode_t'(s_mode);
            gesture_reg <= gesture_t'(s_gesture);
            now_reg     <= s_now_ms;
        end
    end

    hmsct_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .mode    (mode_reg),
        .gesture (gesture_reg),
        .now_ms  (now_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_action        = out_reg.action;
    assign m_hours_out     = out_reg.hours;
    assign m_minutes_out   = out_reg.minutes;
    assign m_seconds_out   = out_reg.seconds;
    assign m_field_out     = out_reg.field;
    assign m_remaining_out = out_reg.remaining;
    assign m_running_out   = out_reg.running;
    assign m_finished_out  = out_reg.finished;

    // a finished countdown must have been started
    a_done_needs_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_finished_out || m_running_out))
        else $error("finished without running");

    // a finished countdown has nothing left
    a_done_means_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_finished_out |-> (m_remaining_out == '0))
        else $error("finished with time remaining");

    // set fields stay in range and the field selector never reaches three
    a_fields_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hours_out <= HOURS_LAST) && (m_minutes_out <= MINSEC_LAST)
                    && (m_seconds_out <= MINSEC_LAST) && (m_field_out <= FIELD_SECONDS))
        else $error("set field out of range");

    // a taken beat occupies the input register on the next cycle
    a_beat_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted beat lost");

endmodule

`default_nettype wire
